### rtl/core/fpr_pkg.sv
// Shared constants and types for the frame parser with resync.
`default_nettype none
package fpr_pkg;
    localparam int RING_DEPTH_DEF  = 512;
    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int HDR_LEN         = 8;

    localparam logic [7:0] SYNC0 = 8'hAA;
    localparam logic [7:0] SYNC1 = 8'h55;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POLL  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_IDLE  = 2'd3;

    // Command handed from the front part to the back part.
    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] read_index;
        logic       overflow;
    } fpr_cmd_t;
endpackage
`default_nettype wire

### rtl/core/fpr_front.sv
// Front part: accepts items, queues one command, appends pushed bytes to the ring.
`default_nettype none
module fpr_front #(
    parameter int RING_DEPTH = fpr_pkg::RING_DEPTH_DEF,
    parameter int PW = $clog2(RING_DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_mode,
    input  wire logic [7:0]       s_rx_byte,
    input  wire logic [8:0]       s_read_index,
    input  wire logic [PW-1:0]    rd_ptr,
    output logic [PW-1:0]         wr_ptr,
    output logic                  ring_we,
    output logic [PW-1:0]         ring_waddr,
    output logic [7:0]            ring_wdata,
    output logic                  cmd_valid,
    output fpr_pkg::fpr_cmd_t     cmd,
    input  wire logic             cmd_take
);
    import fpr_pkg::*;

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic          full_reg, full_next;
    fpr_cmd_t      cmd_reg, cmd_next;
    logic [7:0]    rx_byte_reg, rx_byte_next;
    logic          acc, is_full, push_take;

    assign s_ready   = !full_reg;
    assign acc       = s_valid && s_ready;
    assign is_full   = (wr_ptr_reg + PW'(1)) == rd_ptr;
    assign wr_ptr    = wr_ptr_reg;
    assign cmd_valid = full_reg;
    // The byte enters the ring only when the back part takes the command, so the
    // previous parse has already settled the read pointer.
    assign push_take  = cmd_take && (cmd_reg.mode == MODE_PUSH);
    assign ring_we    = push_take && !is_full;
    assign ring_waddr = wr_ptr_reg;
    assign ring_wdata = rx_byte_reg;

    always_comb begin
        cmd          = cmd_reg;
        cmd.overflow = (cmd_reg.mode == MODE_PUSH) && is_full;
    end

    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        full_next    = full_reg;
        cmd_next     = cmd_reg;
        rx_byte_next = rx_byte_reg;
        if (cmd_take) begin
            full_next = 1'b0;
        end
        if (ring_we) begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (acc) begin
            full_next           = 1'b1;
            cmd_next.mode       = s_mode;
            cmd_next.read_index = s_read_index;
            cmd_next.overflow   = 1'b0;
            rx_byte_next        = s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            full_reg   <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            full_reg   <= full_next;
        end
        cmd_reg     <= cmd_next;
        rx_byte_reg <= rx_byte_next;
    end
endmodule
`default_nettype wire

### rtl/core/fpr_back.sv
// Back part: runs the parse over the ring, fills the frame store, builds results.
`default_nettype none
module fpr_back #(
    parameter int RING_DEPTH  = fpr_pkg::RING_DEPTH_DEF,
    parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF,
    parameter int PW = $clog2(RING_DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cmd_valid,
    input  wire fpr_pkg::fpr_cmd_t cmd,
    output logic                  cmd_take,
    input  wire logic [PW-1:0]    wr_ptr,
    output logic [PW-1:0]         rd_ptr,
    input  wire logic             ring_we,
    input  wire logic [PW-1:0]    ring_waddr,
    input  wire logic [7:0]       ring_wdata,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_frame_ready,
    output logic [8:0]            m_frame_length,
    output logic [7:0]            m_read_byte,
    output logic                  m_overflow,
    output logic [8:0]            m_held_count
);
    import fpr_pkg::*;

    localparam int FRAME_MAX = MAX_PAYLOAD + HDR_LEN;
    localparam int FW = $clog2(FRAME_MAX + 1);
    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_HDR, ST_HDR_WAIT, ST_SUM, ST_FOLD, ST_COPY,
        ST_RDWAIT, ST_OUT
    } state_t;

    logic [7:0] ring_mem [RING_DEPTH];
    logic [7:0] frame_mem [FRAME_MAX];

    state_t        state_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] raddr_reg;
    logic [7:0]    rdata_reg;
    logic [7:0]    hdr_reg [8];
    logic [3:0]    hcnt_reg;
    logic [FW-1:0] k_reg;
    logic [31:0]   sum_reg;
    logic [7:0]    hi_byte_reg;
    logic          pend_reg;
    logic [FW-1:0] fwaddr_reg;
    logic          fwe_reg;
    logic [7:0]    fdata_reg;
    logic [8:0]    ridx_reg;
    logic [7:0]    frame_rdata_reg;
    logic          res_fr_reg, res_ovf_reg;
    logic [8:0]    res_len_reg;
    logic          out_valid_reg;
    logic          o_fr_reg, o_ovf_reg;
    logic [8:0]    o_len_reg, o_held_reg;
    logic [7:0]    o_rb_reg;
    logic [1:0]    mode_reg;

    logic [PW-1:0] held;
    logic [15:0]   len;
    logic [FW-1:0] flen;

    assign held = wr_ptr - rd_ptr_reg;
    assign len  = {hdr_reg[2], hdr_reg[3]};
    assign flen = FW'(len[LW-1:0]) + FW'(HDR_LEN);
    assign rd_ptr = rd_ptr_reg;
    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid;
    assign m_valid = out_valid_reg;
    assign m_frame_ready  = o_fr_reg;
    assign m_frame_length = o_len_reg;
    assign m_read_byte    = o_rb_reg;
    assign m_overflow     = o_ovf_reg;
    assign m_held_count   = o_held_reg;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        rdata_reg <= ring_mem[raddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (fwe_reg) begin
            frame_mem[fwaddr_reg[FW-1:0]] <= fdata_reg;
        end
        frame_rdata_reg <= frame_mem[ridx_reg[FW-1:0]];
    end

    // The read address is registered, and rdata_reg registers the ring data at that address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            fwe_reg       <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            fwe_reg       <= (state_reg == ST_COPY) && !pend_reg;
            out_valid_reg <= (out_valid_reg && !m_ready) ||
                             ((state_reg == ST_OUT) && (!out_valid_reg || m_ready));
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        mode_reg    <= cmd.mode;
                        ridx_reg    <= cmd.read_index;
                        res_ovf_reg <= cmd.overflow;
                        res_fr_reg  <= 1'b0;
                        res_len_reg <= '0;
                        if (cmd.mode == MODE_READ) begin
                            state_reg <= ST_RDWAIT;
                        end else if (cmd.mode == MODE_IDLE) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (32'(held) > 32'(HDR_LEN)) begin
                        raddr_reg <= rd_ptr_reg;
                        hcnt_reg  <= '0;
                        pend_reg  <= 1'b1;
                        state_reg <= ST_HDR;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_HDR: begin
                    // Pipeline: issue address k, capture its data on the next pass.
                    raddr_reg <= raddr_reg + PW'(1);
                    pend_reg  <= 1'b0;
                    if (!pend_reg) begin
                        hdr_reg[hcnt_reg[2:0]] <= rdata_reg;
                        hcnt_reg <= hcnt_reg + 4'd1;
                        if (hcnt_reg == 4'd7) begin
                            state_reg <= ST_HDR_WAIT;
                        end
                    end
                end
                ST_HDR_WAIT: begin
                    if (hdr_reg[0] != SYNC0) begin
                        rd_ptr_reg <= rd_ptr_reg + PW'(1);
                        state_reg  <= ST_CHECK;
                    end else if (hdr_reg[1] != SYNC1 ||
                                 (hdr_reg[2] ^ hdr_reg[3]) != hdr_reg[5] ||
                                 32'(len) > 32'(MAX_PAYLOAD)) begin
                        rd_ptr_reg <= rd_ptr_reg + PW'(2);
                        state_reg  <= ST_CHECK;
                    end else if (32'(len) + 32'(HDR_LEN) > 32'(held)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        raddr_reg <= rd_ptr_reg + PW'(HDR_LEN);
                        k_reg     <= '0;
                        sum_reg   <= '0;
                        pend_reg  <= 1'b1;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    raddr_reg <= raddr_reg + PW'(1);
                    pend_reg  <= 1'b0;
                    if (32'(k_reg) >= 32'(len)) begin
                        state_reg <= ST_FOLD;
                    end else if (!pend_reg) begin
                        k_reg <= k_reg + FW'(1);
                        if (k_reg[0]) begin
                            sum_reg <= sum_reg + {16'd0, hi_byte_reg, rdata_reg};
                        end else if (32'(k_reg) + 32'd1 == 32'(len)) begin
                            sum_reg <= sum_reg + {24'd0, rdata_reg};
                        end else begin
                            hi_byte_reg <= rdata_reg;
                        end
                    end
                end
                ST_FOLD: begin
                    if (sum_reg > 32'hFFFF) begin
                        sum_reg <= {16'd0, sum_reg[31:16]} + {16'd0, sum_reg[15:0]};
                    end else if (~sum_reg[15:0] != {hdr_reg[6], hdr_reg[7]}) begin
                        rd_ptr_reg <= rd_ptr_reg + PW'(2);
                        state_reg  <= ST_CHECK;
                    end else begin
                        raddr_reg <= rd_ptr_reg;
                        k_reg     <= '0;
                        pend_reg  <= 1'b1;
                        state_reg <= ST_COPY;
                    end
                end
                ST_COPY: begin
                    raddr_reg <= raddr_reg + PW'(1);
                    pend_reg  <= 1'b0;
                    if (!pend_reg) begin
                        fwaddr_reg <= k_reg;
                        fdata_reg  <= rdata_reg;
                        k_reg      <= k_reg + FW'(1);
                        if (k_reg + FW'(1) == flen) begin
                            rd_ptr_reg  <= rd_ptr_reg + PW'(flen);
                            res_fr_reg  <= 1'b1;
                            res_len_reg <= 9'(flen);
                            state_reg   <= ST_OUT;
                        end
                    end
                end
                ST_RDWAIT: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        o_fr_reg   <= res_fr_reg;
                        o_len_reg  <= res_len_reg;
                        o_ovf_reg  <= res_ovf_reg;
                        o_rb_reg   <= ((mode_reg == MODE_READ) &&
                                       (32'(ridx_reg) < 32'(FRAME_MAX)))
                                      ? frame_rdata_reg : 8'd0;
                        o_held_reg <= 9'(held);
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/frame_parser_with_resync_core.sv
// Top level of the frame parser with resync.
// The front part holds one accepted transaction while the back part finishes the
// previous one; a pushed byte enters the ring only when the back part takes it.
// A store read or an idle transaction skips the ring parse, and a push or poll with eight
// or fewer bytes held returns its result without a header attempt. Each header attempt
// reads all eight header bytes from the ring, and resyncing over junk repeats that after
// every skip. A good frame is read once for the checksum and once more for the copy
// into the frame store.
// The read_byte field is zero for every transaction other than a store read.
`default_nettype none
module frame_parser_with_resync_core #(
    parameter int RING_DEPTH  = fpr_pkg::RING_DEPTH_DEF,
    parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic [8:0] s_read_index,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_frame_ready,
    output logic [8:0]      m_frame_length,
    output logic [7:0]      m_read_byte,
    output logic            m_overflow,
    output logic [8:0]      m_held_count
);
    import fpr_pkg::*;
    localparam int PW = $clog2(RING_DEPTH);

    logic [PW-1:0] wr_ptr, rd_ptr, ring_waddr;
    logic          ring_we, cmd_valid, cmd_take;
    logic [7:0]    ring_wdata;
    fpr_cmd_t      cmd;

    fpr_front #(.RING_DEPTH(RING_DEPTH), .PW(PW)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_rx_byte, .s_read_index,
        .rd_ptr, .wr_ptr, .ring_we, .ring_waddr, .ring_wdata,
        .cmd_valid, .cmd, .cmd_take
    );

    fpr_back #(.RING_DEPTH(RING_DEPTH), .MAX_PAYLOAD(MAX_PAYLOAD), .PW(PW)) u_back (
        .aclk, .aresetn, .cmd_valid, .cmd, .cmd_take, .wr_ptr, .rd_ptr,
        .ring_we, .ring_waddr, .ring_wdata, .m_valid, .m_ready,
        .m_frame_ready, .m_frame_length, .m_read_byte, .m_overflow, .m_held_count
    );

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_ready == (m_frame_length != 9'd0))) else $error("len");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable({m_frame_ready, m_frame_length, m_read_byte,
                                           m_overflow, m_held_count})) else $error("stable");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("hold");
endmodule
`default_nettype wire

### verif/frame_parser_with_resync_core_test.sv
// Self-checking testbench for the frame parser with resync core.
`timescale 1ns / 100ps
module frame_parser_with_resync_core_test;
    import fpr_pkg::*;

    localparam int RING_SIZE = RING_DEPTH_DEF;
    localparam int STORE_SIZE = MAX_PAYLOAD_DEF + HDR_LEN;
    localparam int STALL_LIMIT = 20000;

    typedef enum int {
        FRM_GOOD, FRM_BAD_SYNC0, FRM_BAD_SYNC1, FRM_BAD_XOR, FRM_TOO_LONG, FRM_BAD_SUM
    } frame_kind_t;

    typedef struct {
        logic       frame_ready;
        logic [8:0] frame_length;
        logic [7:0] read_byte;
        logic       overflow;
        logic [8:0] held_count;
    } parse_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode = MODE_IDLE;
    logic [7:0] s_rx_byte = '0;
    logic [8:0] s_read_index = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_frame_ready;
    logic [8:0] m_frame_length;
    logic [7:0] m_read_byte;
    logic       m_overflow;
    logic [8:0] m_held_count;

    frame_parser_with_resync_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_rx_byte(s_rx_byte), .s_read_index(s_read_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_frame_ready(m_frame_ready),
        .m_frame_length(m_frame_length), .m_read_byte(m_read_byte),
        .m_overflow(m_overflow), .m_held_count(m_held_count)
    );

    // Shadow copy of the ring and the frame store.
    logic [7:0]  ring_mem [RING_SIZE];
    int unsigned wr_ptr = 0;
    int unsigned rd_ptr = 0;
    logic [7:0]  frame_mem [STORE_SIZE];
    int unsigned frame_fill = 0;

    parse_result_t expected_results[$];
    int unsigned   error_count = 0;
    int unsigned   items_sent = 0;
    int unsigned   frames_seen = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   s_idle_pct = 0;
    int unsigned   m_idle_pct = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned ring_held();
        return (wr_ptr + RING_SIZE - rd_ptr) % RING_SIZE;
    endfunction

    function automatic logic [7:0] ring_at(int unsigned off);
        return ring_mem[(rd_ptr + off) % RING_SIZE];
    endfunction

    function automatic logic [15:0] ring_checksum(int unsigned len);
        int unsigned sum;
        int unsigned k;
        sum = 0;
        for (k = 0; k + 1 < len; k += 2)
            sum += {ring_at(HDR_LEN + k), ring_at(HDR_LEN + k + 1)};
        if (len % 2)
            sum += ring_at(HDR_LEN + len - 1);
        while (sum > 16'hffff)
            sum = (sum >> 16) + (sum & 16'hffff);
        return ~sum[15:0];
    endfunction

    // Returns the total length of the frame found, or 0.
    function automatic int unsigned parse_ring();
        int unsigned held;
        int unsigned len;
        int unsigned k;
        logic [7:0] hi;
        logic [7:0] lo;
        held = ring_held();
        while (held > HDR_LEN) begin
            if (ring_at(0) != SYNC0) begin
                rd_ptr = (rd_ptr + 1) % RING_SIZE;
                held -= 1;
                continue;
            end
            hi = ring_at(2);
            lo = ring_at(3);
            len = {hi, lo};
            if (ring_at(1) != SYNC1 || (hi ^ lo) != ring_at(5) || len > MAX_PAYLOAD_DEF) begin
                rd_ptr = (rd_ptr + 2) % RING_SIZE;
                held -= 2;
                continue;
            end
            if (len + HDR_LEN > held)
                return 0;
            if ({ring_at(6), ring_at(7)} != ring_checksum(len)) begin
                rd_ptr = (rd_ptr + 2) % RING_SIZE;
                held -= 2;
                continue;
            end
            for (k = 0; k < len + HDR_LEN; k++)
                frame_mem[k] = ring_at(k);
            if (len + HDR_LEN > frame_fill)
                frame_fill = len + HDR_LEN;
            rd_ptr = (rd_ptr + len + HDR_LEN) % RING_SIZE;
            return len + HDR_LEN;
        end
        return 0;
    endfunction

    function automatic parse_result_t predict_item(logic [1:0] mode, logic [7:0] rx,
                                                   logic [8:0] idx);
        parse_result_t r;
        int unsigned flen;
        flen = 0;
        r.read_byte = '0;
        r.overflow = 1'b0;
        if (mode == MODE_PUSH) begin
            if (ring_held() >= RING_SIZE - 1) begin
                r.overflow = 1'b1;
            end else begin
                ring_mem[wr_ptr] = rx;
                wr_ptr = (wr_ptr + 1) % RING_SIZE;
            end
            flen = parse_ring();
        end else if (mode == MODE_POLL) begin
            flen = parse_ring();
        end else if (mode == MODE_READ) begin
            if (idx < STORE_SIZE)
                r.read_byte = frame_mem[idx];
        end
        r.frame_ready = (flen != 0);
        r.frame_length = flen[8:0];
        r.held_count = 9'(ring_held());
        return r;
    endfunction

    task automatic send_item(logic [1:0] mode, logic [7:0] rx, logic [8:0] idx);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_rx_byte <= rx;
        s_read_index <= idx;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_item(mode, rx, idx));
        items_sent++;
    endtask

    task automatic push_byte(logic [7:0] b);
        send_item(MODE_PUSH, b, 9'($urandom_range(511)));
    endtask

    // Reads an index whose store entry is defined: one written by a past frame,
    // or one past the end of the store.
    task automatic read_store();
        logic [8:0] idx;
        if (frame_fill == 0 || $urandom_range(7) == 0)
            idx = 9'($urandom_range(STORE_SIZE, 511));
        else
            idx = 9'($urandom_range(frame_fill - 1));
        send_item(MODE_READ, 8'($urandom), idx);
    endtask

    task automatic send_frame(int unsigned len, frame_kind_t kind);
        logic [7:0]  bytes[$];
        int unsigned sum;
        int unsigned k;
        int unsigned field;
        logic [15:0] ck;
        for (k = 0; k < len; k++)
            bytes.push_back(8'($urandom));
        sum = 0;
        for (k = 0; k + 1 < len; k += 2)
            sum += {bytes[k], bytes[k + 1]};
        if (len % 2)
            sum += bytes[len - 1];
        while (sum > 16'hffff)
            sum = (sum >> 16) + (sum & 16'hffff);
        ck = ~sum[15:0];
        field = (kind == FRM_TOO_LONG) ? $urandom_range(MAX_PAYLOAD_DEF + 1, 65535) : len;
        if (kind == FRM_BAD_SUM)
            ck ^= 16'(1 << $urandom_range(15));
        push_byte(kind == FRM_BAD_SYNC0 ? 8'($urandom_range(0, 169)) : SYNC0);
        push_byte(kind == FRM_BAD_SYNC1 ? 8'($urandom_range(86, 255)) : SYNC1);
        push_byte(field[15:8]);
        push_byte(field[7:0]);
        push_byte(8'($urandom));
        push_byte((field[15:8] ^ field[7:0]) ^ (kind == FRM_BAD_XOR ? 8'h01 : 8'h00));
        push_byte(ck[15:8]);
        push_byte(ck[7:0]);
        foreach (bytes[i])
            push_byte(bytes[i]);
    endtask

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch on %s: got %0d, expected %0d (item %0d)", field, got, want,
                 items_sent);
        error_count++;
    endtask

    // Result side: compares each transaction against the oldest expectation.
    always @(posedge aclk) begin
        parse_result_t want;
        if (m_valid && m_ready && aresetn) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_frame_ready !== want.frame_ready)
                    report_mismatch("frame_ready", m_frame_ready, want.frame_ready);
                if (m_frame_length !== want.frame_length)
                    report_mismatch("frame_length", m_frame_length, want.frame_length);
                if (m_read_byte !== want.read_byte)
                    report_mismatch("read_byte", m_read_byte, want.read_byte);
                if (m_overflow !== want.overflow)
                    report_mismatch("overflow", m_overflow, want.overflow);
                if (m_held_count !== want.held_count)
                    report_mismatch("held_count", m_held_count, want.held_count);
                if (want.frame_ready)
                    frames_seen++;
            end
        end
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("frame_parser_with_resync_core_test: errors");
            $finish;
        end
    end

    task automatic test_store_edges();
        send_item(MODE_READ, 8'hff, 9'd264);
        send_item(MODE_READ, 8'h00, 9'd511);
        send_item(MODE_IDLE, 8'hff, 9'h1ff);
        send_item(MODE_POLL, 8'h00, 9'h000);
    endtask

    task automatic test_good_frames();
        send_frame(0, FRM_GOOD);
        send_frame(1, FRM_GOOD);
        send_frame(4, FRM_GOOD);
        read_store();
        send_item(MODE_READ, 8'h00, 9'd0);
    endtask

    task automatic test_bad_frames();
        send_frame(2, FRM_BAD_SYNC0);
        send_frame(2, FRM_BAD_SYNC1);
        send_frame(3, FRM_BAD_XOR);
        send_frame(2, FRM_TOO_LONG);
        send_frame(3, FRM_BAD_SUM);
        repeat (3) send_item(MODE_POLL, 8'h00, 9'h000);
    endtask

    task automatic test_incomplete_frame();
        int unsigned k;
        push_byte(SYNC0);
        push_byte(SYNC1);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'h00);
        for (k = 0; k < 2; k++)
            send_item(MODE_POLL, 8'h00, 9'h000);
        push_byte(8'hff);
        push_byte(8'hff);
    endtask

    task automatic test_largest_frame();
        send_frame(MAX_PAYLOAD_DEF, FRM_GOOD);
        if (frame_fill == STORE_SIZE)
            send_item(MODE_READ, 8'h00, 9'(STORE_SIZE - 1));
        else
            read_store();
    endtask

    task automatic random_traffic(int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(200, MAX_PAYLOAD_DEF)
                                                : $urandom_range(0, 20);
                if ($urandom_range(3) != 0)
                    send_frame(len, FRM_GOOD);
                else
                    send_frame(len, frame_kind_t'($urandom_range(1, 5)));
            end else if (pick < 72) begin
                repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
            end else if (pick < 80) begin
                send_item(MODE_POLL, 8'($urandom), 9'($urandom_range(511)));
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 4)) read_store();
            end else begin
                send_item(MODE_IDLE, 8'($urandom), 9'($urandom_range(511)));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_store_edges();
        test_good_frames();
        test_bad_frames();
        test_incomplete_frame();
        test_largest_frame();
        s_idle_pct = 20;
        m_idle_pct = 75;
        random_traffic(550);
        s_idle_pct = 75;
        m_idle_pct = 20;
        random_traffic(550);
        s_idle_pct = 0;
        m_idle_pct = 0;
        random_traffic(550);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("Sent %0d transactions, %0d frames recovered, across three stall profiles.",
                 items_sent, frames_seen);
        if (error_count == 0 && expected_results.size() == 0)
            $display("frame_parser_with_resync_core_test: clean");
        else
            $display("frame_parser_with_resync_core_test: errors");
        $finish;
    end
endmodule

### filelist.f
rtl/core/fpr_pkg.sv
rtl/core/fpr_front.sv
rtl/core/fpr_back.sv
rtl/core/frame_parser_with_resync_core.sv
verif/frame_parser_with_resync_core_test.sv
